// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the mixer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACM_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mixer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ACM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mixer assertion failed");

`endif

// File: rtl/acm_pkg.sv
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types and constants of the audio channel mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acm_pkg;

    localparam int MAX_VOLUME_DEF = 255;

    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int ACC_W    = 24;
    localparam int GAIN_W   = 17;
    localparam int TERM_W   = 35;
    localparam int RECIP_SHIFT = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_VOLUME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_WIDE   = 1'b1;

    localparam logic [VOL_W-1:0] GLOBAL_VOLUME_RESET = 8'd128;

    typedef struct packed {
        logic load;
        logic mul;
        logic recip;
        logic corr;
        logic scale;
        logic accum;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_stall;
    } sts_t;

endpackage

`default_nettype wire

// File: rtl/acm_ctrl.sv
// ----------------------------------------------------------------------------
// acm_ctrl
// Sequencer that steps one input word through the mixer datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acm_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  acm_pkg::sts_t     sts,
    output acm_pkg::cmd_t     cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_RECIP = 7'b0000100,
        ST_CORR  = 7'b0001000,
        ST_SCALE = 7'b0010000,
        ST_ACCUM = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_CORR;
            end
            ST_CORR:
            begin
                cmd.corr   = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = sts.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!sts.out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/acm_datapath.sv
// ----------------------------------------------------------------------------
// acm_datapath
// Gain computation, sample scaling, saturating accumulation and output clip.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module acm_datapath #(
    parameter int MAX_VOLUME = acm_pkg::MAX_VOLUME_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [acm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [acm_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic [23:0]                   s_tdata,
    input  wire logic [1:0]                    s_tuser,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,
    output logic [0:0]                         m_tuser,
    input  acm_pkg::cmd_t                      cmd,
    output acm_pkg::sts_t                      sts
);

    localparam int GW  = acm_pkg::GAIN_W;
    localparam int RS  = acm_pkg::RECIP_SHIFT;
    localparam int RW  = RS + 1;
    localparam int QW  = GW + RW;
    localparam int MW  = GW + 8;
    localparam int TW  = acm_pkg::TERM_W;
    localparam int AW  = acm_pkg::ACC_W;
    localparam int SW  = acm_pkg::SAMPLE_W;

    localparam logic [RW-1:0] RECIP = RW'((64'd1 << RS) / MAX_VOLUME);
    localparam logic [MW-1:0] MAXV  = MW'(MAX_VOLUME);
    localparam logic signed [AW+11:0] ACC_HI = (AW+12)'((64'sd1 <<< (AW-1)) - 1);
    localparam logic signed [AW+11:0] ACC_LO = -(AW+12)'(64'sd1 <<< (AW-1));

    logic [7:0]        gvol_reg, gvol_next;
    logic              owide_reg, owide_next;

    logic [SW-1:0]     raw_reg;
    logic [7:0]        vol_reg;
    logic              swide_reg;
    logic              has_reg;
    logic              last_reg;

    logic [GW-1:0]     prod_reg, prod_next;
    logic [GW-1:0]     q0_reg, q0_next;
    logic [GW-1:0]     gain_reg, gain_next;
    logic signed [TW-1:0] term_reg, term_next;
    logic signed [AW-1:0] acc_reg, acc_next;

    logic              ovalid_reg, ovalid_next;
    logic [SW-1:0]     odata_reg, odata_next;
    logic              oclip_reg, oclip_next;

    logic [8:0]        vol_p1;
    logic [16:0]       vol_mul;
    logic [QW-1:0]     recip_prod;
    logic [MW-1:0]     q0_times_m;
    logic [MW-1:0]     remainder;
    logic signed [16:0] op_s;
    logic signed [TW-1:0] contrib;
    logic signed [AW+11:0] sum;
    logic signed [AW:0]   acc_bias;
    logic signed [16:0]   acc_div;

    always_comb
    begin
        gvol_next  = gvol_reg;
        owide_next = owide_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                acm_pkg::CFG_GLOBAL_VOLUME: gvol_next  = cfg_data;
                acm_pkg::CFG_OUTPUT_WIDE:   owide_next = cfg_data[0];
                default:                    gvol_next  = gvol_reg;
            endcase
        end
    end

    always_comb
    begin
        vol_p1     = {1'b0, vol_reg} + 9'd1;
        vol_mul    = 17'(vol_p1) * 17'(gvol_reg);
        prod_next  = {vol_mul[15:0], 1'b0};

        recip_prod = QW'(prod_reg) * QW'(RECIP);
        q0_next    = recip_prod[RS+GW-1:RS];

        q0_times_m = MW'(q0_reg) * MAXV;
        remainder  = MW'(prod_reg) - q0_times_m;
        gain_next  = (remainder >= MAXV) ? q0_reg + GW'(1) : q0_reg;

        if (swide_reg)
        begin
            op_s = 17'($signed(raw_reg));
        end
        else
        begin
            op_s = $signed({9'b0, raw_reg[7:0]}) - 17'sd127;
        end
        term_next = TW'(op_s) * TW'($signed({1'b0, gain_reg}));

        if (swide_reg)
        begin
            contrib = (term_reg + (term_reg[TW-1] ? TW'(255) : TW'(0))) >>> 8;
        end
        else
        begin
            contrib = term_reg;
        end
        sum = (AW+12)'(acc_reg) + (AW+12)'(contrib);
        acc_next = acc_reg;
        if (cmd.accum && has_reg)
        begin
            priority if (sum > ACC_HI)
            begin
                acc_next = AW'(ACC_HI);
            end
            else if (sum < ACC_LO)
            begin
                acc_next = AW'(ACC_LO);
            end
            else
            begin
                acc_next = AW'(sum);
            end
        end
        else if (cmd.emit)
        begin
            acc_next = '0;
        end
    end

    always_comb
    begin
        acc_bias = (AW+1)'(acc_reg) + (acc_reg[AW-1] ? (AW+1)'(255) : (AW+1)'(0));
        acc_div  = 17'(acc_bias >>> 8);
        odata_next  = odata_reg;
        oclip_next  = oclip_reg;
        ovalid_next = ovalid_reg && !m_tready;
        if (cmd.emit)
        begin
            ovalid_next = 1'b1;
            if (owide_reg)
            begin
                priority if (acc_reg > AW'(32767))
                begin
                    odata_next = 16'h7FFF;
                    oclip_next = 1'b1;
                end
                else if (acc_reg < -AW'(32768))
                begin
                    odata_next = 16'h8000;
                    oclip_next = 1'b1;
                end
                else
                begin
                    odata_next = acc_reg[15:0];
                    oclip_next = 1'b0;
                end
            end
            else
            begin
                priority if (acc_div > 17'sd127)
                begin
                    odata_next = 16'd255;
                    oclip_next = 1'b1;
                end
                else if (acc_div < -17'sd127)
                begin
                    odata_next = 16'd0;
                    oclip_next = 1'b1;
                end
                else
                begin
                    odata_next = 16'(acc_div + 17'sd127);
                    oclip_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gvol_reg   <= acm_pkg::GLOBAL_VOLUME_RESET;
            owide_reg  <= 1'b0;
            acc_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            gvol_reg   <= gvol_next;
            owide_reg  <= owide_next;
            acc_reg    <= acc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg   <= s_tdata[15:0];
            vol_reg   <= s_tdata[23:16];
            swide_reg <= s_tuser[0];
            has_reg   <= s_tuser[1];
            last_reg  <= s_tlast;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.recip)
        begin
            q0_reg <= q0_next;
        end
        if (cmd.corr)
        begin
            gain_reg <= gain_next;
        end
        if (cmd.scale)
        begin
            term_reg <= term_next;
        end
        odata_reg <= odata_next;
        oclip_reg <= oclip_next;
    end

    assign sts.last      = last_reg;
    assign sts.out_stall = ovalid_reg && !m_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = oclip_reg;

    `ACM_ASSERT_SAME(a_emit_not_stalled, clk, rst_n, cmd.emit, !(ovalid_reg && !m_tready))
    `ACM_ASSERT_NEXT(a_emit_shows_word, clk, rst_n, cmd.emit, m_tvalid)
    `ACM_ASSERT_NEXT(a_emit_clears_acc, clk, rst_n, cmd.emit, acc_reg == '0)

endmodule

`default_nettype wire

// File: rtl/audio_channel_mixer_clip.sv
// ----------------------------------------------------------------------------
// audio_channel_mixer_clip
// Mixes channel samples of one frame into a single clipped output sample.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_*       in   tdata: sample_raw[15:0], channel_volume[23:16];
//                tuser: sample_wide, has_sample; tlast: last_in_frame
// m_*       out  tdata: mixed_out[15:0]; tuser: was_clipped
// cfg_*     in   index 0 global_volume, index 1 output_wide
//
// Each input word passes through gain multiply, reciprocal divide,
// remainder correction, sample scale and accumulate, which run in turn
// through one datapath, and the frame end adds an output clip step.
// The accumulator and configuration registers reset asynchronously on rst_n.
// A held output word stalls only the clip step of the next frame end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module audio_channel_mixer_clip #(
    parameter int MAX_VOLUME = acm_pkg::MAX_VOLUME_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [acm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [acm_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // sample_raw [15:0], channel_volume [23:16]
    input  wire logic [23:0]                   s_tdata,
    // sample_wide [0], has_sample [1]
    input  wire logic [1:0]                    s_tuser,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // mixed_out [15:0]
    output logic [15:0]                        m_tdata,
    // was_clipped [0]
    output logic [0:0]                         m_tuser
);

    acm_pkg::cmd_t cmd;
    acm_pkg::sts_t sts;

    acm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    acm_datapath #(
        .MAX_VOLUME (MAX_VOLUME)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
